// File: rtl/ubd_pkg.sv
package ubd_pkg;

  localparam int ClkW   = 27;
  localparam int RateW  = 24;
  localparam int FracW  = 14;
  localparam int PrescW = 16;
  localparam int StageW = 4;
  localparam int CodeW  = 8;
  localparam int WordW  = 16;

  // integer quotient cells, then fraction cells
  localparam int IntSteps  = ClkW;
  localparam int FracSteps = FracW;
  localparam int ProdW     = RateW + FracW;

  localparam logic [FracW-1:0] FracScale = 14'd10000;
  localparam logic [ClkW-1:0]  OsRatio   = 27'd16;
  localparam logic [ClkW-1:0]  ClockHzRst = 27'd8000000;
  localparam logic [PrescW-1:0] PrescMax = 16'hffff;

  localparam int BandCount = 34;
  localparam logic [CodeW-1:0] LastBandCode = 8'hfe;

  // band limits are midpoints of the nominal fraction points
  localparam logic [FracW-1:0] BandLimit [BandCount] = '{
    14'd264,  14'd622,  14'd775,  14'd918,  14'd1126, 14'd1341, 14'd1550, 14'd1908,
    14'd2185, 14'd2363, 14'd2751, 14'd3167, 14'd3455, 14'd3664, 14'd3878, 14'd4144,
    14'd4332, 14'd4690, 14'd5358, 14'd5859, 14'd6128, 14'd6343, 14'd6549, 14'd6834,
    14'd7074, 14'd7682, 14'd7932, 14'd8168, 14'd8398, 14'd8518, 14'd8661, 14'd8877,
    14'd9087, 14'd9229
  };

  localparam logic [CodeW-1:0] BandCode [BandCount] = '{
    8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h11,
    8'h21, 8'h22, 8'h44, 8'h25, 8'h49, 8'h4a, 8'h52, 8'h92,
    8'h53, 8'h55, 8'haa, 8'h6b, 8'had, 8'hb5, 8'hb6, 8'hd6,
    8'hb7, 8'hbb, 8'hdd, 8'hed, 8'hee, 8'hbf, 8'hdf, 8'hef,
    8'hfb, 8'hfd
  };

  // first band whose limit lies above the fraction
  function automatic logic [CodeW-1:0] pick_second_stage(input logic [FracW-1:0] frac);
    logic [CodeW-1:0] code;
    code = LastBandCode;
    for (int i = BandCount - 1; i >= 0; i--) begin
      if (frac < BandLimit[i]) begin
        code = BandCode[i];
      end
    end
    return code;
  endfunction

endpackage

// File: rtl/ubd_div_cell.sv
module ubd_div_cell #(
  parameter int W  = 27,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem,
  input  logic [W-1:0]  in_num,
  input  logic [DW-1:0] in_div,
  output logic          out_valid,
  output logic [DW-1:0] out_rem,
  output logic [W-1:0]  out_num,
  output logic [DW-1:0] out_div
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_next;
  logic [W-1:0]  num_next;

  // one restoring step: bring down the next dividend bit, try the subtract
  always_comb begin
    trial    = {in_rem, in_num[W-1]};
    diff     = trial - {1'b0, in_div};
    ge       = ~diff[DW];
    rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
    num_next = {in_num[W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_rem <= rem_next;
    out_num <= num_next;
    out_div <= in_div;
  end

endmodule

// File: rtl/ubd_div_chain.sv
module ubd_div_chain #(
  parameter int W     = 27,
  parameter int DW    = 24,
  parameter int STEPS = 27
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem,
  input  logic [W-1:0]  in_num,
  input  logic [DW-1:0] in_div,
  output logic          out_valid,
  output logic [DW-1:0] out_rem,
  output logic [W-1:0]  out_num,
  output logic [DW-1:0] out_div
);

  logic          v   [STEPS+1];
  logic [DW-1:0] rem [STEPS+1];
  logic [W-1:0]  num [STEPS+1];
  logic [DW-1:0] dv  [STEPS+1];

  assign v[0]   = in_valid;
  assign rem[0] = in_rem;
  assign num[0] = in_num;
  assign dv[0]  = in_div;

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    ubd_div_cell #(
      .W  (W),
      .DW (DW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v[i]),
      .in_rem    (rem[i]),
      .in_num    (num[i]),
      .in_div    (dv[i]),
      .out_valid (v[i+1]),
      .out_rem   (rem[i+1]),
      .out_num   (num[i+1]),
      .out_div   (dv[i+1])
    );
  end

  assign out_valid = v[STEPS];
  assign out_rem   = rem[STEPS];
  assign out_num   = num[STEPS];
  assign out_div   = dv[STEPS];

endmodule

// File: rtl/uart_baud_divisor_calc.sv
// channel   | handshake              | fields
// ----------+------------------------+-------------------------------------------------
// request   | start, busy            | bit_rate
// result    | done (one-cycle strobe)| prescaler, first_stage, oversample, second_stage,
//           |                        | fraction, modulation_word
// config    | cfg_we                 | cfg_data (clock_hz)
//
// a new word is taken every cycle; busy is never raised
// each result passes, in order, through 27 integer quotient cells,
// one scaling register, 14 fraction quotient cells and one output register
// the rate is set by the cell row, one quotient bit per cell per cycle
// rst (synchronous) empties the row and sets clock_hz to 8000000
// the receiver cannot stall: done is a strobe and results are never held
module uart_baud_divisor_calc import ubd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [RateW-1:0]  bit_rate,
  input  logic              cfg_we,
  input  logic [ClkW-1:0]   cfg_data,
  output logic              done,
  output logic [PrescW-1:0] prescaler,
  output logic [StageW-1:0] first_stage,
  output logic              oversample,
  output logic [CodeW-1:0]  second_stage,
  output logic [FracW-1:0]  fraction,
  output logic [WordW-1:0]  modulation_word
);

  // source clock register
  logic [ClkW-1:0] clock_hz;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= ClockHzRst;
    end else if (cfg_we) begin
      clock_hz <= cfg_data;
    end
  end

  // fully pipelined, so a request is always taken
  assign busy = 1'b0;

  // a zero rate is treated as a rate of one
  logic [RateW-1:0] rate_eff;
  assign rate_eff = (bit_rate == '0) ? RateW'(1) : bit_rate;

  // integer part: N = clock_hz / rate, remainder left in rem
  logic             q_valid;
  logic [RateW-1:0] q_rem;
  logic [ClkW-1:0]  q_num;
  logic [RateW-1:0] q_div;

  ubd_div_chain #(
    .W     (ClkW),
    .DW    (RateW),
    .STEPS (IntSteps)
  ) u_int_chain (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start & ~busy),
    .in_rem    ('0),
    .in_num    (clock_hz),
    .in_div    (rate_eff),
    .out_valid (q_valid),
    .out_rem   (q_rem),
    .out_num   (q_num),
    .out_div   (q_div)
  );

  // scale the remainder by 10000 for the fraction division
  logic             sc_valid;
  logic [ProdW-1:0] sc_prod;
  logic [ClkW-1:0]  sc_n;
  logic [RateW-1:0] sc_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_valid <= 1'b0;
    end else begin
      sc_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    sc_prod <= {{FracW{1'b0}}, q_rem} * {{RateW{1'b0}}, FracScale};
    sc_n    <= q_num;
    sc_div  <= q_div;
  end

  // fraction part: the product is below rate * 2^14, so its upper bits are
  // already a valid partial remainder; the low bits are brought down one per
  // cell while N rides along below them and ends up on top
  localparam int FracNumW = FracW + ClkW;

  logic                f_valid;
  logic [RateW-1:0]    f_rem;
  logic [FracNumW-1:0] f_num;
  logic [RateW-1:0]    f_div;

  ubd_div_chain #(
    .W     (FracNumW),
    .DW    (RateW),
    .STEPS (FracSteps)
  ) u_frac_chain (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sc_valid),
    .in_rem    (sc_prod[ProdW-1:FracW]),
    .in_num    ({sc_prod[FracW-1:0], sc_n}),
    .in_div    (sc_div),
    .out_valid (f_valid),
    .out_rem   (f_rem),
    .out_num   (f_num),
    .out_div   (f_div)
  );

  // remainder and divisor of the fraction are not needed past this point
  logic            f_unused;
  assign f_unused = ^{f_rem, f_div};

  // final fields
  logic [ClkW-1:0]   n_val;
  logic [FracW-1:0]  frac_val;
  logic              os_next;
  logic [ClkW-1:0]   presc_raw;
  logic [PrescW-1:0] prescaler_next;
  logic [StageW-1:0] first_next;
  logic [CodeW-1:0]  second_next;

  always_comb begin
    n_val     = f_num[FracNumW-1:FracW];
    frac_val  = f_num[FracW-1:0];
    os_next   = (n_val > OsRatio);
    // sixteen-times oversampling divides N by 16, the low nibble goes to stage one
    presc_raw = os_next ? (n_val >> 4) : n_val;
    if (presc_raw > {{(ClkW-PrescW){1'b0}}, PrescMax}) begin
      prescaler_next = PrescMax;
    end else begin
      prescaler_next = presc_raw[PrescW-1:0];
    end
    first_next  = os_next ? n_val[StageW-1:0] : '0;
    second_next = pick_second_stage(frac_val);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= f_valid & ~f_unused | f_valid & f_unused;
    end
  end

  always_ff @(posedge clk) begin
    prescaler       <= prescaler_next;
    first_stage     <= first_next;
    oversample      <= os_next;
    second_stage    <= second_next;
    fraction        <= frac_val;
    // second stage on the high byte, first stage on bits 7..4, oversample on bit 0
    modulation_word <= {second_next, first_next, 3'b000, os_next};
  end

endmodule

// File: rtl/ubd_checker.sv
module ubd_checker import ubd_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              busy,
  input logic              done,
  input logic [PrescW-1:0] prescaler,
  input logic [StageW-1:0] first_stage,
  input logic              oversample,
  input logic [CodeW-1:0]  second_stage,
  input logic [FracW-1:0]  fraction,
  input logic [WordW-1:0]  modulation_word
);

  // requests are never refused
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  // packed word agrees with the separate fields
  a_word_pack: assert property (@(posedge clk) disable iff (rst)
    done |-> (modulation_word[15:8] == second_stage) && (modulation_word[7:4] == first_stage)
             && (modulation_word[3:1] == 3'b000) && (modulation_word[0] == oversample))
    else $error("modulation word mismatch");

  // without oversampling the first stage is zero
  a_first_zero: assert property (@(posedge clk) disable iff (rst)
    done && !oversample |-> first_stage == '0)
    else $error("first stage set without oversampling");

  // oversampling means N is at least 17, so the prescaler is at least 1
  a_presc_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && oversample |-> prescaler != '0)
    else $error("zero prescaler while oversampling");

  // fraction is scaled by 10000 and stays below it
  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    done |-> fraction < FracScale)
    else $error("fraction out of range");

endmodule

bind uart_baud_divisor_calc ubd_checker u_ubd_checker (.*);
